@@ rtl/core/swab_pkg.sv @@
// ---------------------------------------------------------------------------
// swab_pkg: shared types and constants
// Field widths, register indexes, ring beat types and the sequencer states
// used across the airtime budget block.
// ---------------------------------------------------------------------------
`default_nettype none

package swab_pkg;

  // Field widths
  localparam int TIME_W   = 32;
  localparam int LEN_W    = 16;
  localparam int USED_W   = 21;
  localparam int BUDGET_W = 22;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Usage output saturates here
  localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};

  // Command codes
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET = 2'd1;

  // Register reset values
  localparam logic [TIME_W-1:0]   WINDOW_RST = 32'd3600000;
  localparam logic [BUDGET_W-1:0] BUDGET_RST = 22'd36000;

  // One ring record
  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [LEN_W-1:0]  length;
  } ring_rec_t;

  // Ring write request
  typedef struct packed {
    logic      en;
    ring_rec_t rec;
  } ring_wr_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/swab_cfg_if.sv @@
// ---------------------------------------------------------------------------
// swab_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface swab_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [swab_pkg::CFG_IDX_W-1:0]  index;
  logic [swab_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/swab_in_if.sv @@
// ---------------------------------------------------------------------------
// swab_in_if: command channel
// Valid/ready channel carrying one record or query command per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface swab_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [swab_pkg::TIME_W-1:0] now_ms;
  logic [swab_pkg::LEN_W-1:0]  duration_ms;

  modport source (output valid, output cmd, output now_ms, output duration_ms, input ready);
  modport sink   (input valid, input cmd, input now_ms, input duration_ms, output ready);
endinterface

`default_nettype wire

@@ rtl/core/swab_out_if.sv @@
// ---------------------------------------------------------------------------
// swab_out_if: usage report channel
// Valid/ready channel carrying one usage report per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface swab_out_if;
  logic                         valid;
  logic                         ready;
  logic [swab_pkg::USED_W-1:0]   used_ms;
  logic [swab_pkg::BUDGET_W-1:0] remaining_ms;
  logic                         exhausted;
  logic                         warning;

  modport source (output valid, output used_ms, output remaining_ms, output exhausted,
                  output warning, input ready);
  modport sink   (input valid, input used_ms, input remaining_ms, input exhausted,
                  input warning, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sliding_window_airtime_budget.sv @@
// ---------------------------------------------------------------------------
// sliding_window_airtime_budget: sliding window duty cycle limiter
// Records transmissions in a ring and, for every command, sums the
// durations of the records younger than the window and reports usage
// against the airtime budget.
// ---------------------------------------------------------------------------
//   channel  dir  beat contents
//   cfg      in   index, data          register write, always ready
//   req      in   cmd, now_ms, duration_ms
//   rsp      out  used_ms, remaining_ms, exhausted, warning
//
// Between the accepting edge and the edge that loads the report, a command
// reads each filled ring slot in turn (filled counted after the command; a
// query on an empty ring skips the reads), then drains the read and
// accumulate stages, then takes the final step.
// req is ready only while the sequencer is idle, so a new command is not
// taken until the last one's report is loaded. A report waiting on rsp does
// not block the next command; the sequencer holds its final step until the
// report register is free. Reset is synchronous; it empties the ring and
// restores the registers.
// ---------------------------------------------------------------------------
`default_nettype none

module sliding_window_airtime_budget #(
  parameter int RING_ENTRIES = 32
) (
  input wire          clk,
  input wire          rst,
  swab_cfg_if.sink    cfg,
  swab_in_if.sink     req,
  swab_out_if.source  rsp
);
  import swab_pkg::*;

  localparam int IDX_W = $clog2(RING_ENTRIES);
  localparam int CNT_W = $clog2(RING_ENTRIES + 1);
  localparam int SUM_W = LEN_W + CNT_W;
  localparam int CMP_W = ((SUM_W > BUDGET_W) ? SUM_W : BUDGET_W) + 3;

  // Configuration registers
  logic [TIME_W-1:0]   window;
  logic [BUDGET_W-1:0] budget;

  // Sequencer
  state_t state;
  state_t state_next;
  logic   req_ready;
  logic   rd_en;
  logic   load_out;
  logic   accept;
  logic   last_rd;

  // Datapath
  logic [TIME_W-1:0] now_q;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_vld;
  logic              hit_vld;
  logic [LEN_W-1:0]  hit_len;
  logic [SUM_W-1:0]  acc;
  logic [TIME_W-1:0] age;
  ring_wr_t          ring_wr;
  ring_rec_t         rd_data;
  logic [CNT_W-1:0]  filled;

  // Report
  logic [CMP_W-1:0]    acc_ext;
  logic [CMP_W-1:0]    budget_ext;
  logic                exhausted_c;
  logic                warning_c;
  logic [USED_W-1:0]   used_c;
  logic [BUDGET_W-1:0] remaining_c;
  logic                out_valid;
  logic [USED_W-1:0]   out_used;
  logic [BUDGET_W-1:0] out_remaining;
  logic                out_exhausted;
  logic                out_warning;

  assign cfg.ready = 1'b1;

  // Take register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RST;
      budget <= BUDGET_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WINDOW: window <= cfg.data;
        REG_BUDGET: budget <= cfg.data[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept  = req.valid && req_ready;
  assign last_rd = ((CNT_W'(rd_idx) + 1'b1) == filled);

  // Ring store
  assign ring_wr.en         = accept && (req.cmd == CMD_RECORD);
  assign ring_wr.rec.stamp  = req.now_ms;
  assign ring_wr.rec.length = req.duration_ms;

  swab_ring #(
    .RING_ENTRIES (RING_ENTRIES)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr      (ring_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_idx),
    .rd_data (rd_data),
    .filled  (filled)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req.cmd == CMD_QUERY && filled == '0) ? ST_FINISH : ST_SUM;
        end
      end
      ST_SUM: begin
        if (last_rd) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld && !hit_vld) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req_ready = 1'b0;
    rd_en     = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE:   req_ready = 1'b1;
      ST_SUM:    rd_en     = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: load_out  = !out_valid || rsp.ready;
      default:   ;
    endcase
  end

  assign req.ready = req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_vld  <= 1'b0;
      hit_vld <= 1'b0;
    end else begin
      state   <= state_next;
      rd_vld  <= rd_en;
      hit_vld <= rd_vld;
    end
  end

  // Age of the entry just read
  assign age = now_q - rd_data.stamp;

  // Walk the ring: read, age compare, accumulate
  always_ff @(posedge clk) begin
    if (accept) begin
      now_q  <= req.now_ms;
      rd_idx <= '0;
    end else if (rd_en) begin
      rd_idx <= rd_idx + 1'b1;
    end
    hit_len <= (age < window) ? rd_data.length : '0;
    if (accept) begin
      acc <= '0;
    end else if (hit_vld) begin
      acc <= acc + SUM_W'(hit_len);
    end
  end

  // Report against the budget; warning is used*5 >= budget*4
  assign acc_ext     = CMP_W'(acc);
  assign budget_ext  = CMP_W'(budget);
  assign exhausted_c = (acc_ext >= budget_ext);
  assign warning_c   = ((acc_ext + (acc_ext << 2)) >= (budget_ext << 2));
  assign used_c      = (acc_ext > CMP_W'(USED_MAX)) ? USED_MAX : acc_ext[USED_W-1:0];
  assign remaining_c = exhausted_c ? '0 : BUDGET_W'(budget_ext - acc_ext);

  // Hold the report until the sink takes the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_used      <= used_c;
      out_remaining <= remaining_c;
      out_exhausted <= exhausted_c;
      out_warning   <= warning_c;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.used_ms      = out_used;
  assign rsp.remaining_ms = out_remaining;
  assign rsp.exhausted    = out_exhausted;
  assign rsp.warning      = out_warning;

endmodule

`default_nettype wire

@@ rtl/core/swab_ring.sv @@
// ---------------------------------------------------------------------------
// swab_ring: transmission record ring
// Holds the timestamp/duration records, the write slot and the fill count,
// and gives one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module swab_ring #(
  parameter int RING_ENTRIES = 32
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire swab_pkg::ring_wr_t               wr,
  input  wire                                   rd_en,
  input  wire  [$clog2(RING_ENTRIES)-1:0]       rd_addr,
  output swab_pkg::ring_rec_t                   rd_data,
  output logic [$clog2(RING_ENTRIES+1)-1:0]     filled
);
  import swab_pkg::*;

  localparam int IDX_W = $clog2(RING_ENTRIES);
  localparam int CNT_W = $clog2(RING_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(RING_ENTRIES);

  ring_rec_t        mem [RING_ENTRIES];
  logic [IDX_W-1:0] write_slot;

  // Store the record and read one entry
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[write_slot] <= wr.rec;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Advance the write slot and count filled slots up to the ring size
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      filled     <= '0;
    end else if (wr.en) begin
      write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
      if (filled != FULL_CNT) begin
        filled <= filled + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ bench/airtime_usage_checker.sv @@
// ---------------------------------------------------------------------------
// airtime_usage_checker: usage report predictor and scoreboard
// Watches the register, command and report channels. Keeps its own ring
// of transmission records and its own copy of the window and budget,
// predicts one usage report per accepted command and compares each
// accepted report field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module airtime_usage_checker #(
  parameter int RING_ENTRIES = 32
) (
  input  logic clk,
  input  logic rst,
  swab_cfg_if  cfg,
  swab_in_if   req,
  swab_out_if  rsp,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import swab_pkg::*;

  typedef struct packed {
    logic [USED_W-1:0]   used_ms;
    logic [BUDGET_W-1:0] remaining_ms;
    logic                exhausted;
    logic                warning;
  } usage_rpt_t;

  logic [TIME_W-1:0]   window_len;
  logic [BUDGET_W-1:0] budget_len;
  logic [TIME_W-1:0]   stamp_ring [RING_ENTRIES];
  logic [LEN_W-1:0]    length_ring [RING_ENTRIES];
  int                  next_slot = 0;
  int                  filled = 0;
  usage_rpt_t          reports_due [$];
  int                  errors = 0;

  // Store a record if asked, then sum the airtime still inside the window
  function automatic usage_rpt_t account_airtime(logic cmd, logic [TIME_W-1:0] now,
                                                 logic [LEN_W-1:0] dur);
    logic [63:0]       total;
    logic [63:0]       budget64;
    logic [TIME_W-1:0] age;
    usage_rpt_t        rpt;
    if (cmd == CMD_RECORD) begin
      stamp_ring[next_slot] = now;
      length_ring[next_slot] = dur;
      next_slot = (next_slot + 1) % RING_ENTRIES;
      if (filled < RING_ENTRIES) filled++;
    end
    total = '0;
    for (int k = 0; k < filled; k++) begin
      age = now - stamp_ring[k];
      if (age < window_len) total += 64'(length_ring[k]);
    end
    budget64 = 64'(budget_len);
    rpt.used_ms = (total > 64'(USED_MAX)) ? USED_MAX : total[USED_W-1:0];
    rpt.remaining_ms = (total >= budget64) ? '0 : BUDGET_W'(budget64 - total);
    rpt.exhausted = (total >= budget64);
    rpt.warning = (total * 100 >= budget64 * 80);
    return rpt;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Track registers, predict on command beats, compare on report beats
  always @(posedge clk) begin : watch
    usage_rpt_t want;
    if (rst) begin
      window_len = WINDOW_RST;
      budget_len = BUDGET_RST;
      next_slot = 0;
      filled = 0;
      reports_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_WINDOW: window_len = cfg.data[TIME_W-1:0];
          REG_BUDGET: budget_len = cfg.data[BUDGET_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (reports_due.size() == 0) begin
          errors++;
          $display("%0t: report beat with none outstanding, used_ms %0d", $time, rsp.used_ms);
        end else begin
          want = reports_due.pop_front();
          check_field("used_ms", 64'(want.used_ms), 64'(rsp.used_ms));
          check_field("remaining_ms", 64'(want.remaining_ms), 64'(rsp.remaining_ms));
          check_field("exhausted", 64'(want.exhausted), 64'(rsp.exhausted));
          check_field("warning", 64'(want.warning), 64'(rsp.warning));
        end
      end
      if (req.valid && req.ready)
        reports_due.push_back(account_airtime(req.cmd, req.now_ms, req.duration_ms));
    end
    pending <= reports_due.size();
    fail_count <= errors;
  end

endmodule

@@ bench/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: airtime budget block testbench
// Drives register writes and record/query commands with random gaps and
// random report back-pressure. A directed run covers window edges, time
// wrap, the warning and exhausted thresholds and the zero window and zero
// budget cases; random phases then sweep several window/budget settings.
// The checker instance predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import swab_pkg::*;

  localparam int RING_ENTRIES = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [TIME_W-1:0] BASE_T = 32'h8000_0000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   req_quiet = 0;
  int   rsp_quiet = 0;
  int unsigned cycle_cnt = 0;
  logic [TIME_W-1:0] clock_ms = '0;
  logic [TIME_W-1:0] recent_stamps [$];

  swab_cfg_if cfg ();
  swab_in_if  req ();
  swab_out_if rsp ();

  sliding_window_airtime_budget #(.RING_ENTRIES(RING_ENTRIES)) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .req(req),
    .rsp(rsp)
  );

  airtime_usage_checker #(.RING_ENTRIES(RING_ENTRIES)) u_chk (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .req(req),
    .rsp(rsp),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle cycles before the next beat, with occasional stretches of none
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) quiet = $urandom_range(10, 40);
    return $urandom_range(0, 12);
  endfunction

  // Stall the report channel at random
  initial begin : report_sink
    int stall;
    forever begin
      stall = draw_gap(rsp_quiet);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("sliding_window_airtime_budget: mismatch");
      $finish;
    end
  end

  // Hold a register beat until accepted; valid stays up for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic cfg_done();
    cfg.valid <= 1'b0;
  endtask

  // Send one command beat after a random gap filled with junk payload
  task automatic send_cmd(input logic cmd, input logic [TIME_W-1:0] now,
                          input logic [LEN_W-1:0] dur);
    int gap;
    gap = draw_gap(req_quiet);
    if (gap > 0) begin
      req.valid <= 1'b0;
      req.cmd <= 1'($urandom_range(0, 1));
      req.now_ms <= $urandom();
      req.duration_ms <= LEN_W'($urandom());
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.now_ms <= now;
    req.duration_ms <= dur;
    do @(posedge clk); while (!req.ready);
    if (cmd == CMD_RECORD) begin
      recent_stamps.push_back(now);
      if (recent_stamps.size() > RING_ENTRIES) void'(recent_stamps.pop_front());
    end
  endtask

  // Drop valid and wait until every report has come back
  task automatic wait_idle();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic directed_items();
    // empty ring, then wrap of the time base
    send_cmd(CMD_QUERY, 32'd0, 16'hFFFF);
    send_cmd(CMD_RECORD, 32'hFFFF_FFF0, 16'd0);
    send_cmd(CMD_RECORD, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(CMD_QUERY, 32'd5, 16'd0);
    // age one below the window counts, age equal to it does not
    send_cmd(CMD_QUERY, 32'hFFFF_FFFF + WINDOW_RST - 32'd1, 16'd0);
    send_cmd(CMD_QUERY, 32'hFFFF_FFFF + WINDOW_RST, 16'd0);
    // walk across the warning and exhausted thresholds
    send_cmd(CMD_RECORD, BASE_T, 16'd28799);
    send_cmd(CMD_RECORD, BASE_T, 16'd1);
    send_cmd(CMD_RECORD, BASE_T, 16'd7199);
    send_cmd(CMD_RECORD, BASE_T, 16'd1);
    send_cmd(CMD_QUERY, BASE_T + 32'd100, 16'hFFFF);
    // zero window
    wait_idle();
    write_reg(REG_WINDOW, '0);
    cfg_done();
    send_cmd(CMD_QUERY, BASE_T, 16'd0);
    send_cmd(CMD_RECORD, BASE_T, 16'd500);
    // zero budget
    wait_idle();
    write_reg(REG_WINDOW, 32'(WINDOW_RST));
    write_reg(REG_BUDGET, '0);
    cfg_done();
    send_cmd(CMD_QUERY, BASE_T, 16'd0);
    // shortest window; writes to unused indexes must change nothing
    wait_idle();
    write_reg(REG_WINDOW, 32'd1);
    write_reg(REG_BUDGET, 32'd2);
    write_reg(REG_SPARE_A, $urandom());
    write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
    cfg_done();
    send_cmd(CMD_RECORD, BASE_T + 32'd5000, 16'd1);
    send_cmd(CMD_QUERY, BASE_T + 32'd5001, 16'd0);
    send_cmd(CMD_RECORD, BASE_T + 32'd5001, 16'd3);
  endtask

  // Random commands paced against the window, durations scaled to the budget
  task automatic random_items(input int n, input logic [TIME_W-1:0] win,
                              input logic [BUDGET_W-1:0] bud);
    int                sel;
    int                cap;
    logic [TIME_W-1:0] span;
    logic [LEN_W-1:0]  dur;
    logic              cmd;
    span = (win >> 3) + 32'd1;
    cap = (int'(bud) >> 2) + 1;
    if (cap > 65535) cap = 65535;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 5)
        clock_ms = $urandom();
      else if (sel < 15 && recent_stamps.size() > 0)
        clock_ms = recent_stamps[$urandom_range(0, recent_stamps.size() - 1)] + win
                   - 32'($urandom_range(0, 1));
      else if (sel >= 30)
        clock_ms = clock_ms + 32'($urandom_range(0, span));
      case ($urandom_range(0, 9))
        0: dur = '0;
        1: dur = '1;
        2: dur = LEN_W'($urandom());
        default: dur = LEN_W'($urandom_range(0, cap));
      endcase
      cmd = ($urandom_range(0, 9) < 6) ? CMD_RECORD : CMD_QUERY;
      send_cmd(cmd, clock_ms, dur);
    end
  endtask

  // Reprogram both registers while idle, then run random commands
  task automatic run_phase(input int n, input logic [TIME_W-1:0] win,
                           input logic [BUDGET_W-1:0] bud);
    logic [CFG_DATA_W-1:0] bud_word;
    bud_word = ($urandom() & 32'hFFC0_0000) | 32'(bud);
    wait_idle();
    write_reg(REG_WINDOW, win);
    write_reg(REG_BUDGET, bud_word);
    cfg_done();
    if ($urandom_range(0, 1) == 1) clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 4096));
    random_items(n, win, bud);
  endtask

  initial begin
    cfg.valid <= 1'b0;
    cfg.index <= REG_WINDOW;
    cfg.data <= '0;
    req.valid <= 1'b0;
    req.cmd <= CMD_QUERY;
    req.now_ms <= '0;
    req.duration_ms <= '0;
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    directed_items();
    run_phase(200, 32'd1000, 22'd2000);
    run_phase(80, 32'd1, 22'd1);
    run_phase(150, 32'hFFFF_FFFF, 22'h3F_FFFF);
    run_phase(120, 32'hFFFF_FFFF, 22'd1000000);
    for (int p = 0; p < 4; p++)
      run_phase(100, $urandom_range(100, 200000), BUDGET_W'($urandom_range(1, 400000)));
    run_phase(200, WINDOW_RST, BUDGET_RST);

    // drain, then allow for one full ring walk
    wait_idle();
    repeat (RING_ENTRIES + 8) @(posedge clk);
    if (fail_count == 0)
      $display("sliding_window_airtime_budget: match");
    else
      $display("sliding_window_airtime_budget: mismatch");
    $finish;
  end

endmodule
